/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, disabled while reset is low.
`define AST_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion sampled on the rising clock edge, active during reset too.
`define AST_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/cdt_pkg.sv */
// Package of the two-body clutch derivative block: widths, register indexes,
// curve constants and saturation helpers. Depends on nothing.
package cdt_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int SLOPE_FRAC    = 16;
    localparam int SEGMENTS      = 4;

    localparam int FIELD_W   = 32;
    localparam int IN_W      = 6 * FIELD_W;
    localparam int OUT_W     = 5 * FIELD_W;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 3;

    // Pipeline depth from accepted word to output register, and the stage
    // whose register holds the clutch torque.
    localparam int LATENCY      = 8;
    localparam int TORQUE_STAGE = 5;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ENGAGED         = 3'd0;
    localparam t_cfg_idx CFG_DAMPING         = 3'd1;
    localparam t_cfg_idx CFG_FRICTION_IN     = 3'd2;
    localparam t_cfg_idx CFG_FRICTION_OUT    = 3'd3;
    localparam t_cfg_idx CFG_INV_INERTIA_IN  = 3'd4;
    localparam t_cfg_idx CFG_INV_INERTIA_OUT = 3'd5;

    localparam logic [CFG_W-1:0] CFG_RESET = 31'd65536;

    typedef logic signed [63:0] t_wide;
    localparam t_wide SAT_MAX = 64'sd2147483647;
    localparam t_wide SAT_MIN = -64'sd2147483648;

    // Breakpoints as Q32 radians (-5, -3, 0, 5.5, 10 degrees).
    localparam longint BRK_Q32 [0:SEGMENTS] = '{
        -64'sd374806603, -64'sd224883962, 64'sd0, 64'sd412287263, 64'sd749613206
    };
    localparam longint SEG_TORQUE [0:SEGMENTS-1] = '{-64'sd1000, -64'sd30, 64'sd0, 64'sd50};
    // Segment slopes, torque per radian in Q16.
    localparam longint SEG_SLOPE [0:SEGMENTS-1] = '{
        64'sd1821144060, 64'sd37549362, 64'sd34135784, 64'sd2877784425
    };

    function automatic logic signed [31:0] sat32(input t_wide v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[31:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[31:0];
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Breakpoint rounded half up from Q32 to the working format.
    function automatic longint brk_qf(input int frac, input int idx);
        longint half;
        half = longint'(1) <<< (31 - frac);
        return (BRK_Q32[idx] + half) >>> (32 - frac);
    endfunction

endpackage

/* rtl/cdt_torque.sv */
// Clutch torque pipeline: angle and speed differences, curve segment,
// slope and damping products, engage gating. Depends on cdt_pkg.
module cdt_torque #(
    parameter int FRAC_BITS = cdt_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic                  i_engaged,
    input  logic [cdt_pkg::CFG_W-1:0] i_damping,
    input  logic signed [31:0]    i_angle_in,
    input  logic signed [31:0]    i_angle_out,
    input  logic signed [31:0]    i_speed_in,
    input  logic signed [31:0]    i_speed_out,
    output logic signed [31:0]    o_torque
);
    import cdt_pkg::*;

    localparam longint BRK [0:SEGMENTS-1] = '{
        brk_qf(FRAC_BITS, 0), brk_qf(FRAC_BITS, 1), brk_qf(FRAC_BITS, 2), brk_qf(FRAC_BITS, 3)
    };
    localparam longint ONE = longint'(1) <<< FRAC_BITS;
    localparam longint BASE [0:SEGMENTS-1] = '{
        SEG_TORQUE[0] * ONE, SEG_TORQUE[1] * ONE, SEG_TORQUE[2] * ONE, SEG_TORQUE[3] * ONE
    };
    localparam logic signed [34:0] LIM_HI = 35'sd1073741824;
    localparam logic signed [34:0] LIM_LO = -35'sd1073741824;

    // Stage 1
    logic signed [32:0] r_dphi, r_dw;
    // Stage 2
    logic [1:0]          r_seg2;
    logic signed [31:0]  r_diff;
    logic signed [63:0]  r_dprod;
    // Stage 3
    logic [1:0]          r_seg3;
    logic signed [63:0]  r_sprod;
    logic signed [31:0]  r_damp3;
    // Stage 4
    logic signed [31:0]  r_curve, r_damp4;
    // Stage 5
    logic signed [31:0]  r_torque;

    logic [1:0]          n_seg;
    longint              brk_sel;
    logic signed [34:0]  diff_w;
    logic signed [31:0]  n_diff;
    logic signed [32:0]  slope_sel;
    longint              base_sel;

    // Segment select: the highest inner breakpoint at or below the difference.
    always_comb begin
        n_seg = 2'd0;
        if (longint'(r_dphi) >= BRK[1]) begin
            n_seg = 2'd1;
        end
        if (longint'(r_dphi) >= BRK[2]) begin
            n_seg = 2'd2;
        end
        if (longint'(r_dphi) >= BRK[3]) begin
            n_seg = 2'd3;
        end
        case (n_seg)
            2'd0:    brk_sel = BRK[0];
            2'd1:    brk_sel = BRK[1];
            2'd2:    brk_sel = BRK[2];
            default: brk_sel = BRK[3];
        endcase
        diff_w = 35'(longint'(r_dphi) - brk_sel);
        if (diff_w > LIM_HI) begin
            n_diff = LIM_HI[31:0];
        end else if (diff_w < LIM_LO) begin
            n_diff = LIM_LO[31:0];
        end else begin
            n_diff = diff_w[31:0];
        end
    end

    always_comb begin
        case (r_seg2)
            2'd0:    slope_sel = 33'(SEG_SLOPE[0]);
            2'd1:    slope_sel = 33'(SEG_SLOPE[1]);
            2'd2:    slope_sel = 33'(SEG_SLOPE[2]);
            default: slope_sel = 33'(SEG_SLOPE[3]);
        endcase
        case (r_seg3)
            2'd0:    base_sel = BASE[0];
            2'd1:    base_sel = BASE[1];
            2'd2:    base_sel = BASE[2];
            default: base_sel = BASE[3];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dphi   <= {i_angle_out[31], i_angle_out} - {i_angle_in[31], i_angle_in};
            r_dw     <= {i_speed_out[31], i_speed_out} - {i_speed_in[31], i_speed_in};

            r_seg2   <= n_seg;
            r_diff   <= n_diff;
            r_dprod  <= $signed({1'b0, i_damping}) * r_dw;

            r_seg3   <= r_seg2;
            r_sprod  <= r_diff * slope_sel;
            r_damp3  <= sat32(r_dprod >>> FRAC_BITS);

            r_curve  <= sat32(base_sel + (r_sprod >>> SLOPE_FRAC));
            r_damp4  <= r_damp3;

            r_torque <= i_engaged ? sat32(longint'(r_curve) + longint'(r_damp4)) : 32'sd0;
        end
    end

    assign o_torque = r_torque;

endmodule

/* rtl/cdt_accel.sv */
// Acceleration pipeline of one body: friction product, net torque,
// reciprocal-inertia product, saturation. Depends on cdt_pkg.
module cdt_accel #(
    parameter int FRAC_BITS = cdt_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [cdt_pkg::CFG_W-1:0] i_fric,
    input  logic [cdt_pkg::CFG_W-1:0] i_inv,
    input  logic signed [31:0]    i_speed,
    input  logic signed [31:0]    i_drive,
    input  logic signed [32:0]    i_torque,
    output logic signed [31:0]    o_accel
);
    import cdt_pkg::*;

    localparam int FW  = 64 - FRAC_BITS;
    localparam int DLY = TORQUE_STAGE - 1;

    logic signed [63:0]   r_fprod;
    logic signed [FW-1:0] r_fterm [DLY];
    logic signed [31:0]   r_drive [TORQUE_STAGE];
    logic signed [31:0]   r_net;
    logic signed [63:0]   r_aprod;
    logic signed [31:0]   r_accel;

    // The friction term and the drive are delayed so that they meet the
    // torque of the same word at the net torque stage.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fprod    <= $signed({1'b0, i_fric}) * i_speed;
            r_fterm[0] <= FW'(r_fprod >>> FRAC_BITS);
            for (int k = 1; k < DLY; k++) begin
                r_fterm[k] <= r_fterm[k-1];
            end
            r_drive[0] <= i_drive;
            for (int k = 1; k < TORQUE_STAGE; k++) begin
                r_drive[k] <= r_drive[k-1];
            end
            r_net   <= sat32(longint'(i_torque) - longint'(r_fterm[DLY-1])
                             + longint'(r_drive[TORQUE_STAGE-1]));
            r_aprod <= r_net * $signed({1'b0, i_inv});
            r_accel <= sat32(r_aprod >>> FRAC_BITS);
        end
    end

    assign o_accel = r_accel;

endmodule

/* rtl/clutch_two_body_derivative.sv */
// Top level of the two-body clutch derivative block: stream ports,
// configuration registers, stage valid bits. Depends on cdt_pkg, cdt_torque, cdt_accel.
//
// Usage: each word on the slave stream carries the state of two bodies joined
// by a clutch; the block returns one word on the master stream with the two
// angle rates, the two angular accelerations and the clutch torque, all
// signed fixed point with FRAC_BITS fraction bits, saturated to 32 bits.
// Configuration registers (engage flag, damping, frictions, reciprocal
// inertias) are written through the plain write port while no word is in
// flight; a write takes effect at the clock edge where i_cfg_we is high.
// The block takes one word every cycle unless a result in the output register
// is not yet taken by the receiver. Stage 1 forms the angle and speed
// differences and the friction products, stage 2 picks the curve segment and
// forms the damping product, stage 3 the slope product, stage 4 the curve
// term, stage 5 the gated clutch torque, stage 6 the net torques, stage 7
// the reciprocal-inertia products and stage 8 their saturation.
// When the receiver holds i_m_tready low while a result waits, the whole
// pipeline freezes and o_s_tready drops; nothing is lost or repeated.
// A synchronous low reset clears the stage valid bits and loads the reset
// values of the registers (engaged, all coefficients 65536, 1.0 at FRAC_BITS 16).
module clutch_two_body_derivative #(
    parameter int FRAC_BITS = cdt_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // angle_in, speed_in, angle_out, speed_out, drive_in, drive_out (32 bits each)
    input  logic [cdt_pkg::IN_W-1:0]      i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // angle_rate_in, accel_in, angle_rate_out, accel_out, coupling_torque (32 bits each)
    output logic [cdt_pkg::OUT_W-1:0]     o_m_tdata,
    input  logic                          i_cfg_we,
    input  logic [cdt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cdt_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import cdt_pkg::*;

    localparam int TQ_DLY = LATENCY - TORQUE_STAGE;

    logic             r_engaged;
    logic [CFG_W-1:0] r_damping, r_fric_in, r_fric_out, r_inv_in, r_inv_out;
    logic [LATENCY-1:0] r_valid;

    logic signed [31:0] r_rate_in  [LATENCY];
    logic signed [31:0] r_rate_out [LATENCY];
    logic signed [31:0] r_tq       [TQ_DLY];

    logic               en;
    logic signed [31:0] angle_in, speed_in, angle_out, speed_out, drive_in, drive_out;
    logic signed [31:0] torque, accel_in, accel_out;
    logic signed [32:0] torque_in_w, torque_out_w;

    assign angle_in  = i_s_tdata[0*FIELD_W +: FIELD_W];
    assign speed_in  = i_s_tdata[1*FIELD_W +: FIELD_W];
    assign angle_out = i_s_tdata[2*FIELD_W +: FIELD_W];
    assign speed_out = i_s_tdata[3*FIELD_W +: FIELD_W];
    assign drive_in  = i_s_tdata[4*FIELD_W +: FIELD_W];
    assign drive_out = i_s_tdata[5*FIELD_W +: FIELD_W];

    // The pipeline advances whenever the output register is empty or taken.
    assign en         = !r_valid[LATENCY-1] || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_valid[LATENCY-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_engaged  <= 1'b1;
            r_damping  <= CFG_RESET;
            r_fric_in  <= CFG_RESET;
            r_fric_out <= CFG_RESET;
            r_inv_in   <= CFG_RESET;
            r_inv_out  <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENGAGED:         r_engaged  <= i_cfg_wdata[0];
                CFG_DAMPING:         r_damping  <= i_cfg_wdata;
                CFG_FRICTION_IN:     r_fric_in  <= i_cfg_wdata;
                CFG_FRICTION_OUT:    r_fric_out <= i_cfg_wdata;
                CFG_INV_INERTIA_IN:  r_inv_in   <= i_cfg_wdata;
                CFG_INV_INERTIA_OUT: r_inv_out  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (en) begin
            r_valid <= {r_valid[LATENCY-2:0], i_s_tvalid};
        end
    end

    // Angle rates are the speeds, gated by the engage flag, carried down the
    // pipeline; the torque is held from its stage to the output register.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rate_in[0]  <= r_engaged ? speed_in  : 32'sd0;
            r_rate_out[0] <= r_engaged ? speed_out : 32'sd0;
            for (int k = 1; k < LATENCY; k++) begin
                r_rate_in[k]  <= r_rate_in[k-1];
                r_rate_out[k] <= r_rate_out[k-1];
            end
            r_tq[0] <= torque;
            for (int k = 1; k < TQ_DLY; k++) begin
                r_tq[k] <= r_tq[k-1];
            end
        end
    end

    cdt_torque #(
        .FRAC_BITS(FRAC_BITS)
    ) u_torque (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_engaged   (r_engaged),
        .i_damping   (r_damping),
        .i_angle_in  (angle_in),
        .i_angle_out (angle_out),
        .i_speed_in  (speed_in),
        .i_speed_out (speed_out),
        .o_torque    (torque)
    );

    // The input body sees the clutch torque, the output body its negation.
    assign torque_in_w  = {torque[31], torque};
    assign torque_out_w = -torque_in_w;

    cdt_accel #(
        .FRAC_BITS(FRAC_BITS)
    ) u_accel_in (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_fric   (r_fric_in),
        .i_inv    (r_inv_in),
        .i_speed  (speed_in),
        .i_drive  (drive_in),
        .i_torque (torque_in_w),
        .o_accel  (accel_in)
    );

    cdt_accel #(
        .FRAC_BITS(FRAC_BITS)
    ) u_accel_out (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_fric   (r_fric_out),
        .i_inv    (r_inv_out),
        .i_speed  (speed_out),
        .i_drive  (drive_out),
        .i_torque (torque_out_w),
        .o_accel  (accel_out)
    );

    assign o_m_tdata = {r_tq[TQ_DLY-1], accel_out, r_rate_out[LATENCY-1],
                        accel_in, r_rate_in[LATENCY-1]};

endmodule

/* rtl/cdt_checker.sv */
// Port-level checker of the two-body clutch derivative block and its bind.
// Depends on cdt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cdt_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_s_tready,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [cdt_pkg::OUT_W-1:0]     o_m_tdata
);
    import cdt_pkg::*;

    // A reset leaves no result word behind.
    `AST_CLK(a_rst_empty, i_clk, !i_rst_n |=> !o_m_tvalid, "output valid after reset")

    // The input side only waits when a finished word is held by the receiver.
    `AST_RST(a_ready_stall, i_clk, i_rst_n, !o_s_tready |-> (o_m_tvalid && !i_m_tready), "input stalled without output stall")

    // A held result word keeps its value until it is taken.
    `AST_RST(a_hold, i_clk, i_rst_n, (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)), "stalled output word changed")

endmodule

bind clutch_two_body_derivative cdt_checker u_cdt_checker (.*);
